// ===== rtl/core/pdf_literal_string_unescape_defines.svh =====
// assertion macros shared by the pdf literal string decoder
`ifndef PDF_LITERAL_STRING_UNESCAPE_DEFINES_SVH
`define PDF_LITERAL_STRING_UNESCAPE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PDFU_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PDFU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pdfu_pkg.sv =====
// types, character codes and helpers for the pdf literal string decoder
`default_nettype none

package pdfu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OCT_SHIFT   = 3;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  // escape letters
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_A      = 8'h61;
  localparam logic [7:0] CHAR_V      = 8'h76;
  localparam logic [7:0] CHAR_E      = 8'h65;

  // one queue entry: all results caused by one input transaction
  typedef struct packed {
    logic       two;      // second byte present
    logic       has0;     // first result carries a byte (0 = empty end marker)
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       last;     // final result of the string
  } pdfu_entry_t;

  function automatic logic [7:0] letter_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CHAR_T:  r = 8'h09;
      CHAR_R:  r = 8'h0D;
      CHAR_N:  r = 8'h0A;
      CHAR_B:  r = 8'h08;
      CHAR_F:  r = 8'h0C;
      CHAR_A:  r = 8'h07;
      CHAR_V:  r = 8'h0B;
      CHAR_E:  r = 8'h1B;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pdfu_front.sv =====
// front end: accepts characters, tracks escape state, builds queue entries
`default_nettype none

module pdfu_front
  import pdfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_in,
  input  wire logic        end_of_string,
  input  wire logic        q_full,
  output logic             q_push,
  output pdfu_entry_t      q_entry
);

  logic       strip_wrapping;
  logic       escape_pending;
  logic [1:0] octal_digits;
  logic [7:0] octal_value;
  logic       at_string_start;

  logic       escape_pending_next;
  logic [1:0] octal_digits_next;
  logic [7:0] octal_value_next;

  logic       accept;
  logic       digit;
  logic [7:0] dsub;
  logic [3:0] dval;
  logic       drop;
  logic       flush;
  logic       e0_v;
  logic       e1_v;
  logic [7:0] e1_b;
  logic [1:0] od_w;
  logic [7:0] ov_w;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign digit    = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
  assign dsub     = char_in - CHAR_ZERO;
  assign dval     = dsub[3:0];
  assign drop     = strip_wrapping && (at_string_start || end_of_string);
  assign flush    = (octal_digits != 2'd0) && (drop || !digit);

  always_comb begin
    e0_v                = flush;
    e1_v                = 1'b0;
    e1_b                = char_in;
    od_w                = flush ? 2'd0 : octal_digits;
    ov_w                = flush ? 8'd0 : octal_value;
    octal_digits_next   = od_w;
    octal_value_next    = ov_w;
    escape_pending_next = escape_pending;

    if (!drop) begin
      if (od_w != 2'd0) begin
        octal_value_next  = (ov_w << OCT_SHIFT) + {4'd0, dval};
        octal_digits_next = od_w + 2'd1;
        // third digit completes the run
        if (od_w == 2'd2) begin
          e1_v              = 1'b1;
          e1_b              = octal_value_next;
          octal_digits_next = 2'd0;
          octal_value_next  = 8'd0;
        end
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (digit) begin
          octal_value_next  = {4'd0, dval};
          octal_digits_next = 2'd1;
        end else if (char_in != CHAR_CR && char_in != CHAR_LF) begin
          e1_v = 1'b1;
          e1_b = letter_escape(char_in);
        end
      end else if (char_in == CHAR_BSLASH) begin
        escape_pending_next = 1'b1;
      end else begin
        e1_v = 1'b1;
        e1_b = char_in;
      end
    end

    if (end_of_string) begin
      // pending octal run flushes at the string end; slot 1 is free then
      if (octal_digits_next != 2'd0) begin
        e1_v = 1'b1;
        e1_b = octal_value_next;
      end
      octal_digits_next   = 2'd0;
      octal_value_next    = 8'd0;
      escape_pending_next = 1'b0;
    end
  end

  always_comb begin
    q_entry.last = end_of_string;
    q_entry.two  = e0_v && e1_v;
    q_entry.byte1 = e1_b;
    if (e0_v) begin
      q_entry.has0  = 1'b1;
      q_entry.byte0 = octal_value;
    end else if (e1_v) begin
      q_entry.has0  = 1'b1;
      q_entry.byte0 = e1_b;
    end else begin
      q_entry.has0  = 1'b0;
      q_entry.byte0 = 8'd0;
    end
    q_push = accept && (e0_v || e1_v || end_of_string);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_wrapping  <= 1'b0;
      escape_pending  <= 1'b0;
      octal_digits    <= 2'd0;
      octal_value     <= 8'd0;
      at_string_start <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        strip_wrapping <= cfg_wr_data;
      end
      if (accept) begin
        escape_pending  <= escape_pending_next;
        octal_digits    <= octal_digits_next;
        octal_value     <= octal_value_next;
        at_string_start <= end_of_string;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pdfu_queue.sv =====
// short entry queue between the front end and the output stage
`default_nettype none

`include "pdf_literal_string_unescape_defines.svh"

module pdfu_queue
  import pdfu_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire pdfu_entry_t push_entry,
  input  wire logic        pop,
  output pdfu_entry_t      head,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pdfu_entry_t    mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `PDFU_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CW'(DEPTH), "queue count overflow")
  `PDFU_ASSERT_IMPL(a_pop_nonempty, clk, rst, pop, count != '0, "pop from empty queue")
  `PDFU_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + CW'(1), "push lost")

endmodule

`default_nettype wire

// ===== rtl/core/pdfu_back.sv =====
// output stage: unpacks queue entries into one result per transaction
`default_nettype none

module pdfu_back
  import pdfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pdfu_entry_t head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       byte_out,
  output logic             has_byte,
  output logic             last_out
);

  logic       sec_pending;
  logic [7:0] sec_byte;
  logic       sec_last;
  logic       load_ok;

  assign load_ok = !out_valid || !out_stall;
  assign q_pop   = load_ok && !sec_pending && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      sec_pending <= 1'b0;
    end else if (load_ok) begin
      if (sec_pending) begin
        out_valid   <= 1'b1;
        sec_pending <= 1'b0;
      end else begin
        out_valid   <= !q_empty;
        sec_pending <= !q_empty && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (sec_pending) begin
        byte_out <= sec_byte;
        has_byte <= 1'b1;
        last_out <= sec_last;
      end else begin
        byte_out <= head.byte0;
        has_byte <= head.has0;
        last_out <= head.last && !head.two;
        sec_byte <= head.byte1;
        sec_last <= head.last;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pdf_literal_string_unescape.sv =====
// top level of the pdf literal string escape decoder
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  cfg     | cfg_wr_en, cfg_wr_data (strip_wrapping)   | in
//  in      | in_valid, in_stall, char_in, end_of_string| in
//  out     | out_valid, out_stall, byte_out, has_byte, | out
//          | last_out                                  |
//
//  one character accepted per cycle while in_stall is low; results pass the queue
//  register, then the output register, one result per cycle while out_stall is
//  low; a character causing two bytes takes two output results, so the queue
//  fills and in_stall rises when such characters come in long runs
//  in_stall is the queue full flag; out_stall only holds the output register
//  rst is synchronous and clears the escape state and strip_wrapping
`default_nettype none

module pdf_literal_string_unescape
  import pdfu_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      byte_out,
  output logic            has_byte,
  output logic            last_out
);

  pdfu_entry_t q_entry;
  pdfu_entry_t q_head;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  pdfu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  pdfu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  pdfu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .byte_out  (byte_out),
    .has_byte  (has_byte),
    .last_out  (last_out)
  );

endmodule

`default_nettype wire

// ===== sim/pdf_literal_string_unescape_tb.sv =====
// self-checking testbench for the pdf literal string escape decoder
module pdf_literal_string_unescape_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdfu_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] ESC_T     = CHAR_T;
  localparam logic [7:0] ESC_R     = CHAR_R;
  localparam logic [7:0] ESC_N     = CHAR_N;
  localparam logic [7:0] ESC_B     = CHAR_B;
  localparam logic [7:0] ESC_F     = CHAR_F;
  localparam logic [7:0] ESC_A     = CHAR_A;
  localparam logic [7:0] ESC_V     = CHAR_V;
  localparam logic [7:0] ESC_E     = CHAR_E;
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_PCT    = "%";

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } decoded_t;

  // predicts decoded bytes per character and holds them until they come out
  class unescape_tracker;
    decoded_t   pending_bytes[$];
    decoded_t   step_out[$];
    bit         strip_parens;
    bit         in_escape;
    logic [1:0] oct_count;
    logic [7:0] oct_value;
    bit         string_start;

    function new();
      strip_parens = 1'b0;
      in_escape    = 1'b0;
      oct_count    = 2'd0;
      oct_value    = 8'h00;
      string_start = 1'b1;
    endfunction

    function void set_strip(bit v);
      strip_parens = v;
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction

    function void emit(logic [7:0] b);
      step_out.push_back('{data: b, has: 1'b1, last: 1'b0});
    endfunction

    function void flush_octal();
      if (oct_count != 2'd0) begin
        emit(oct_value);
        oct_count = 2'd0;
        oct_value = 8'h00;
      end
    endfunction

    function logic [7:0] escaped_value(logic [7:0] c);
      case (c)
        ESC_T:   return 8'h09;
        ESC_R:   return 8'h0D;
        ESC_N:   return 8'h0A;
        ESC_B:   return 8'h08;
        ESC_F:   return 8'h0C;
        ESC_A:   return 8'h07;
        ESC_V:   return 8'h0B;
        ESC_E:   return 8'h1B;
        default: return c;
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic eos);
      bit drop;
      bit digit;
      drop  = strip_parens && (string_start || eos);
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      string_start = eos;
      step_out.delete();
      // a dropped wrapper or a non-digit ends the octal run
      if (oct_count != 2'd0 && (drop || !digit))
        flush_octal();
      if (!drop) begin
        if (oct_count != 2'd0) begin
          oct_value = (oct_value << OCT_SHIFT) + (c - CHAR_ZERO);
          oct_count = oct_count + 2'd1;
          if (oct_count == 2'd3)
            flush_octal();
        end else if (in_escape) begin
          in_escape = 1'b0;
          if (digit) begin
            oct_value = c - CHAR_ZERO;
            oct_count = 2'd1;
          end else if (c != CHAR_CR && c != CHAR_LF) begin
            emit(escaped_value(c));
          end
        end else if (c == CHAR_BSLASH) begin
          in_escape = 1'b1;
        end else begin
          emit(c);
        end
      end
      if (eos) begin
        flush_octal();
        in_escape = 1'b0;
        if (step_out.size() == 0)
          step_out.push_back('{data: 8'h00, has: 1'b0, last: 1'b1});
        else
          step_out[step_out.size() - 1].last = 1'b1;
      end
      foreach (step_out[i])
        pending_bytes.push_back(step_out[i]);
    endfunction

    function string check_byte(logic [7:0] b, logic hb, logic lst);
      decoded_t want;
      if (pending_bytes.size() == 0)
        return $sformatf("unexpected transaction byte=%02h has=%0b last=%0b", b, hb, lst);
      want = pending_bytes.pop_front();
      if (b !== want.data || hb !== want.has || lst !== want.last)
        return $sformatf("got byte=%02h has=%0b last=%0b, want byte=%02h has=%0b last=%0b",
                         b, hb, lst, want.data, want.has, want.last);
      return "";
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] char_in;
  logic       end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] byte_out;
  logic       has_byte;
  logic       last_out;

  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  send_idle_pct = 12;
  int  recv_idle_pct = 52;
  bit  strip_setting = 1'b0;

  logic [7:0] esc_letters [8] = '{ESC_T, ESC_R, ESC_N, ESC_B, ESC_F, ESC_A, ESC_V, ESC_E};
  logic [7:0] literal_escs [4] = '{CH_PCT, CHAR_BSLASH, CH_LPAREN, CH_RPAREN};

  unescape_tracker tracker = new();

  pdf_literal_string_unescape uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_out      (byte_out),
    .has_byte      (has_byte),
    .last_out      (last_out)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && !out_stall) begin
      msg = tracker.check_byte(byte_out, has_byte, last_out);
      if (msg != "")
        report_mismatch(msg);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_char(input logic [7:0] c, input logic eos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    char_in       <= c;
    end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    tracker.note_char(c, eos);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i])
      send_char(s[i], i == s.size() - 1);
  endtask

  // hold the sender off until every decoded byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_strip(input bit v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_strip(v);
    strip_setting = v;
  endtask

  function automatic logic [7:0] random_digit();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic build_string(output logic [7:0] s[$]);
    int pieces;
    s.delete();
    // raw noise now and then
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(255)));
      return;
    end
    if (strip_setting) s.push_back(CH_LPAREN);
    pieces = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(9))
        0, 1: s.push_back(8'($urandom_range(255)));
        2: begin
          s.push_back(CHAR_BSLASH);
          s.push_back(esc_letters[$urandom_range(7)]);
        end
        3, 4: begin
          // one to four digits; four run past the three-digit limit
          s.push_back(CHAR_BSLASH);
          repeat ($urandom_range(1, 4)) s.push_back(random_digit());
        end
        5: begin
          s.push_back(CHAR_BSLASH);
          s.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
        end
        6: begin
          s.push_back(CHAR_BSLASH);
          s.push_back(literal_escs[$urandom_range(3)]);
        end
        7: begin
          s.push_back(CHAR_BSLASH);
          s.push_back(8'($urandom_range(255)));
        end
        default: repeat ($urandom_range(1, 3)) s.push_back(random_digit());
      endcase
    end
    if (!strip_setting && $urandom_range(7) == 0) s.push_back(CHAR_BSLASH);
    if (strip_setting) s.push_back(CH_RPAREN);
    if (s.size() == 0) s.push_back(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int n_items);
    logic [7:0] s[$];
    int sent;
    sent = 0;
    while (sent < n_items) begin
      build_string(s);
      send_string(s);
      sent += s.size();
      if ($urandom_range(39) == 0) drain();
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("pdf_literal_string_unescape regression: fail");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    in_valid      = 1'b0;
    char_in       = 8'h00;
    end_of_string = 1'b0;
    out_stall     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_strip(1'b0);
    send_string('{8'h00, 8'hFF});
    send_string('{CHAR_BSLASH, ESC_N, CHAR_BSLASH, CHAR_NINE, CHAR_NINE, CHAR_NINE,
                  CHAR_BSLASH, "7", "X"});
    // newline escapes give nothing, trailing backslash leaves an empty end marker
    send_string('{CHAR_BSLASH, CHAR_CR, CHAR_BSLASH, CHAR_LF, CHAR_BSLASH});
    send_string('{CHAR_BSLASH, CH_LPAREN, CHAR_BSLASH, "1", "2"});

    write_strip(1'b1);
    send_string('{"Z"});
    send_string('{CH_LPAREN, CHAR_BSLASH, "4", CH_RPAREN});

    write_strip(1'b1);
    run_random(280);

    send_idle_pct = 52;
    recv_idle_pct = 12;
    write_strip(1'b0);
    run_random(280);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_strip(1'b1);
    run_random(145);
    write_strip(1'b0);
    run_random(145);

    drain();
    if (mismatch_count == 0)
      $display("pdf_literal_string_unescape regression: pass");
    else
      $display("pdf_literal_string_unescape regression: fail");
    $finish;
  end

endmodule
